@@ sv/gdda_pkg.sv @@
package gdda_pkg;

  localparam int MAX_YEAR = 9999;

  localparam int D_W    = 5;
  localparam int M_W    = 4;
  localparam int Y_W    = 14;
  localparam int OFF_W  = 23;
  localparam int SER_W  = 22;
  localparam int DIFF_W = 23;
  localparam int AW     = 25;

  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_1Y   = 365;

  // serial of 31 december of the last supported year
  localparam int TOP_DAYS = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  // reciprocal of 100 for p below 2**14
  localparam int RECIP_100 = 5243;
  localparam int RECIP_SH  = 19;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic signed [AW-1:0] res;
    logic                 neg;
    logic                 zero;
  } alu_rsp_t;

  typedef struct packed {
    logic [SER_W-1:0] serial;
    logic             ok;
  } ser_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SER_A0,
    ST_SER_B0,
    ST_GET_A,
    ST_GET_B,
    ST_DIFF,
    ST_ADD,
    ST_LOW,
    ST_HIGH,
    ST_Q400,
    ST_Q100,
    ST_Q4,
    ST_Q1,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  function automatic logic [D_W-1:0] month_days(input logic [M_W-1:0] m, input logic leap);
    logic [D_W-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2: d = leap ? 5'd29 : 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] cum_days(input logic [M_W-1:0] m);
    logic [8:0] c;
    case (m)
      4'd1: c = 9'd0;
      4'd2: c = 9'd31;
      4'd3: c = 9'd59;
      4'd4: c = 9'd90;
      4'd5: c = 9'd120;
      4'd6: c = 9'd151;
      4'd7: c = 9'd181;
      4'd8: c = 9'd212;
      4'd9: c = 9'd243;
      4'd10: c = 9'd273;
      4'd11: c = 9'd304;
      4'd12: c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/gdda_alu.sv @@
module gdda_alu (
  input  gdda_pkg::alu_req_t req,
  output gdda_pkg::alu_rsp_t rsp
);

  logic signed [gdda_pkg::AW-1:0] sum;

  always_comb begin
    case (req.op)
      gdda_pkg::ALU_ADD: sum = req.a + req.b;
      gdda_pkg::ALU_SUB: sum = req.a - req.b;
      default: sum = req.a + req.b;
    endcase
  end

  assign rsp.res  = sum;
  assign rsp.neg  = sum[gdda_pkg::AW-1];
  assign rsp.zero = (sum == '0);

endmodule

@@ sv/gdda_serial.sv @@
module gdda_serial (
  input  logic                      clk,
  input  logic [gdda_pkg::D_W-1:0]  day,
  input  logic [gdda_pkg::M_W-1:0]  month,
  input  logic [gdda_pkg::Y_W-1:0]  year,
  output gdda_pkg::ser_rsp_t        rsp
);

  logic [gdda_pkg::Y_W-1:0] p;
  logic [23:0]              base_nxt;
  logic [27:0]              prod100;
  logic [7:0]               q100_nxt;

  logic [23:0]              base_r;
  logic [7:0]               q100_r;
  logic [gdda_pkg::D_W-1:0] d_r;
  logic [gdda_pkg::M_W-1:0] m_r;
  logic [gdda_pkg::Y_W-1:0] y_r;

  logic [gdda_pkg::Y_W-1:0] p2;
  logic [gdda_pkg::Y_W-1:0] r100;
  logic                     leap;
  logic [gdda_pkg::D_W-1:0] mlen;
  logic                     ok;
  logic [23:0]              total;

  gdda_pkg::ser_rsp_t       rsp_nxt;
  gdda_pkg::ser_rsp_t       rsp_r;

  // stage one: years before, coarse terms
  always_comb begin
    p        = year - gdda_pkg::Y_W'(1);
    base_nxt = 24'(p) * 24'(365) + 24'(p >> 2);
    prod100  = 28'(p) * 28'(gdda_pkg::RECIP_100);
    q100_nxt = 8'(prod100 >> gdda_pkg::RECIP_SH);
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    q100_r <= q100_nxt;
    d_r    <= day;
    m_r    <= month;
    y_r    <= year;
  end

  // stage two: leap rule, month offset, range check
  always_comb begin
    p2    = y_r - gdda_pkg::Y_W'(1);
    r100  = p2 - gdda_pkg::Y_W'(q100_r) * gdda_pkg::Y_W'(100);
    leap  = ((y_r[1:0] == 2'd0) && (r100 != gdda_pkg::Y_W'(99)))
         || ((r100 == gdda_pkg::Y_W'(99)) && (q100_r[1:0] == 2'd3));
    mlen  = gdda_pkg::month_days(m_r, leap);
    ok    = (y_r >= gdda_pkg::Y_W'(1)) && (y_r <= gdda_pkg::Y_W'(gdda_pkg::MAX_YEAR))
         && (m_r >= gdda_pkg::M_W'(1)) && (m_r <= gdda_pkg::M_W'(12))
         && (d_r >= gdda_pkg::D_W'(1)) && (d_r <= mlen);
    total = base_r - 24'(q100_r) + 24'(q100_r >> 2) + 24'(gdda_pkg::cum_days(m_r))
          + 24'((leap && (m_r > gdda_pkg::M_W'(2))) ? 1 : 0) + 24'(d_r);
    rsp_nxt.ok     = ok;
    rsp_nxt.serial = ok ? total[gdda_pkg::SER_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  assign rsp = rsp_r;

endmodule

@@ sv/gregorian_date_day_arithmetic.sv @@
// Proleptic Gregorian day-number unit.
// Input channel: present both dates and the signed offset on the in_ ports
// and raise start while busy is low; that cycle's edge takes the transaction
// and busy stays high until the result has been produced.
// Result channel: out_strobe is high for exactly one cycle and the out_ ports
// carry the result from that cycle until the next strobe; the receiver cannot hold it off, so it
// must take the transaction when the strobe is seen.
// The strobe comes sooner when date A is not a real date or the shifted date
// is out of range, as the divide and month walk are then skipped. One
// transaction is worked on at a time: the next one may start in the cycle
// that carries the strobe.
// The work is done by one shared add/subtract unit: a restoring divide by
// the 400-, 100-, 4- and 1-year cycle lengths (14 steps) and a month walk of
// up to 12 steps, after a two-stage date-to-serial pipeline used for A and B.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// busy and the strobe; a transaction in flight is lost.
module gregorian_date_day_arithmetic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [gdda_pkg::D_W-1:0]            in_day_a,
  input  logic [gdda_pkg::M_W-1:0]            in_month_a,
  input  logic [gdda_pkg::Y_W-1:0]            in_year_a,
  input  logic signed [gdda_pkg::OFF_W-1:0]   in_day_offset,
  input  logic [gdda_pkg::D_W-1:0]            in_day_b,
  input  logic [gdda_pkg::M_W-1:0]            in_month_b,
  input  logic [gdda_pkg::Y_W-1:0]            in_year_b,
  output logic                                out_strobe,
  output logic                                out_valid_a,
  output logic                                out_valid_b,
  output logic [gdda_pkg::SER_W-1:0]          out_serial_a,
  output logic [gdda_pkg::D_W-1:0]            out_sum_day,
  output logic [gdda_pkg::M_W-1:0]            out_sum_month,
  output logic [gdda_pkg::Y_W-1:0]            out_sum_year,
  output logic                                out_range_error,
  output logic signed [gdda_pkg::DIFF_W-1:0]  out_day_difference,
  output logic                                out_a_before_b,
  output logic                                out_a_equals_b
);

  gdda_pkg::state_t state_r, state_nxt;
  logic [2:0]       k_r, k_nxt;
  logic             out_strobe_r, out_strobe_nxt;

  logic [gdda_pkg::D_W-1:0]          da_r, da_nxt, db_r, db_nxt;
  logic [gdda_pkg::M_W-1:0]          ma_r, ma_nxt, mb_r, mb_nxt;
  logic [gdda_pkg::Y_W-1:0]          ya_r, ya_nxt, yb_r, yb_nxt;
  logic signed [gdda_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [gdda_pkg::SER_W-1:0]        sa_r, sa_nxt, sb_r, sb_nxt;
  logic                              va_r, va_nxt, vb_r, vb_nxt;
  logic [gdda_pkg::DIFF_W-1:0]       diff_r, diff_nxt;
  logic signed [gdda_pkg::AW-1:0]    t_r, t_nxt;
  logic [gdda_pkg::SER_W-1:0]        rem_r, rem_nxt;
  logic [4:0]                        q400_r, q400_nxt;
  logic [1:0]                        q100_r, q100_nxt;
  logic [4:0]                        q4_r, q4_nxt;
  logic [1:0]                        q1_r, q1_nxt;
  logic                              leap_r, leap_nxt;
  logic [gdda_pkg::Y_W-1:0]          year_r, year_nxt;
  logic [gdda_pkg::M_W-1:0]          mon_r, mon_nxt;
  logic                              rerr_r, rerr_nxt;

  logic [gdda_pkg::D_W-1:0]          o_day_r, o_day_nxt;
  logic [gdda_pkg::M_W-1:0]          o_month_r, o_month_nxt;
  logic [gdda_pkg::Y_W-1:0]          o_year_r, o_year_nxt;
  logic                              o_va_r, o_va_nxt, o_vb_r, o_vb_nxt;
  logic [gdda_pkg::SER_W-1:0]        o_serial_r, o_serial_nxt;
  logic                              o_rerr_r, o_rerr_nxt;
  logic [gdda_pkg::DIFF_W-1:0]       o_diff_r, o_diff_nxt;
  logic                              o_before_r, o_before_nxt;
  logic                              o_equal_r, o_equal_nxt;

  gdda_pkg::alu_req_t        alu_req;
  gdda_pkg::alu_rsp_t        alu_rsp;
  gdda_pkg::ser_rsp_t        ser_rsp;
  logic [gdda_pkg::D_W-1:0]  ser_day;
  logic [gdda_pkg::M_W-1:0]  ser_month;
  logic [gdda_pkg::Y_W-1:0]  ser_year;
  logic                      before_c;
  logic [gdda_pkg::Y_W-1:0]  year_c;

  gdda_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gdda_serial u_serial (
    .clk   (clk),
    .day   (ser_day),
    .month (ser_month),
    .year  (ser_year),
    .rsp   (ser_rsp)
  );

  always_comb begin
    if (state_r == gdda_pkg::ST_SER_A0) begin
      ser_day   = da_r;
      ser_month = ma_r;
      ser_year  = ya_r;
    end else begin
      ser_day   = db_r;
      ser_month = mb_r;
      ser_year  = yb_r;
    end
  end

  always_comb begin
    if (ya_r != yb_r) begin
      before_c = ya_r < yb_r;
    end else if (ma_r != mb_r) begin
      before_c = ma_r < mb_r;
    end else begin
      before_c = da_r < db_r;
    end
    year_c = gdda_pkg::Y_W'(q400_r) * gdda_pkg::Y_W'(400)
           + gdda_pkg::Y_W'(q100_r) * gdda_pkg::Y_W'(100)
           + gdda_pkg::Y_W'({q4_r, 2'b00}) + gdda_pkg::Y_W'(q1_r) + gdda_pkg::Y_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gdda_pkg::ST_IDLE;
      k_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    da_r       <= da_nxt;
    ma_r       <= ma_nxt;
    ya_r       <= ya_nxt;
    off_r      <= off_nxt;
    db_r       <= db_nxt;
    mb_r       <= mb_nxt;
    yb_r       <= yb_nxt;
    sa_r       <= sa_nxt;
    va_r       <= va_nxt;
    sb_r       <= sb_nxt;
    vb_r       <= vb_nxt;
    diff_r     <= diff_nxt;
    t_r        <= t_nxt;
    rem_r      <= rem_nxt;
    q400_r     <= q400_nxt;
    q100_r     <= q100_nxt;
    q4_r       <= q4_nxt;
    q1_r       <= q1_nxt;
    leap_r     <= leap_nxt;
    year_r     <= year_nxt;
    mon_r      <= mon_nxt;
    rerr_r     <= rerr_nxt;
    o_day_r    <= o_day_nxt;
    o_month_r  <= o_month_nxt;
    o_year_r   <= o_year_nxt;
    o_va_r     <= o_va_nxt;
    o_vb_r     <= o_vb_nxt;
    o_serial_r <= o_serial_nxt;
    o_rerr_r   <= o_rerr_nxt;
    o_diff_r   <= o_diff_nxt;
    o_before_r <= o_before_nxt;
    o_equal_r  <= o_equal_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    out_strobe_nxt = 1'b0;
    da_nxt         = da_r;
    ma_nxt         = ma_r;
    ya_nxt         = ya_r;
    off_nxt        = off_r;
    db_nxt         = db_r;
    mb_nxt         = mb_r;
    yb_nxt         = yb_r;
    sa_nxt         = sa_r;
    va_nxt         = va_r;
    sb_nxt         = sb_r;
    vb_nxt         = vb_r;
    diff_nxt       = diff_r;
    t_nxt          = t_r;
    rem_nxt        = rem_r;
    q400_nxt       = q400_r;
    q100_nxt       = q100_r;
    q4_nxt         = q4_r;
    q1_nxt         = q1_r;
    leap_nxt       = leap_r;
    year_nxt       = year_r;
    mon_nxt        = mon_r;
    rerr_nxt       = rerr_r;
    o_day_nxt      = o_day_r;
    o_month_nxt    = o_month_r;
    o_year_nxt     = o_year_r;
    o_va_nxt       = o_va_r;
    o_vb_nxt       = o_vb_r;
    o_serial_nxt   = o_serial_r;
    o_rerr_nxt     = o_rerr_r;
    o_diff_nxt     = o_diff_r;
    o_before_nxt   = o_before_r;
    o_equal_nxt    = o_equal_r;
    alu_req.op     = gdda_pkg::ALU_SUB;
    alu_req.a      = t_r;
    alu_req.b      = gdda_pkg::AW'(1);

    case (state_r)
      gdda_pkg::ST_IDLE: begin
        if (start) begin
          da_nxt    = in_day_a;
          ma_nxt    = in_month_a;
          ya_nxt    = in_year_a;
          off_nxt   = in_day_offset;
          db_nxt    = in_day_b;
          mb_nxt    = in_month_b;
          yb_nxt    = in_year_b;
          state_nxt = gdda_pkg::ST_SER_A0;
        end
      end
      gdda_pkg::ST_SER_A0: state_nxt = gdda_pkg::ST_SER_B0;
      gdda_pkg::ST_SER_B0: state_nxt = gdda_pkg::ST_GET_A;
      gdda_pkg::ST_GET_A: begin
        sa_nxt    = ser_rsp.serial;
        va_nxt    = ser_rsp.ok;
        state_nxt = gdda_pkg::ST_GET_B;
      end
      gdda_pkg::ST_GET_B: begin
        sb_nxt    = ser_rsp.serial;
        vb_nxt    = ser_rsp.ok;
        state_nxt = gdda_pkg::ST_DIFF;
      end
      gdda_pkg::ST_DIFF: begin
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = gdda_pkg::AW'(sa_r);
        alu_req.b  = gdda_pkg::AW'(sb_r);
        diff_nxt   = (va_r && vb_r) ? alu_rsp.res[gdda_pkg::DIFF_W-1:0] : '0;
        state_nxt  = gdda_pkg::ST_ADD;
      end
      gdda_pkg::ST_ADD: begin
        alu_req.op = gdda_pkg::ALU_ADD;
        alu_req.a  = gdda_pkg::AW'(sa_r);
        alu_req.b  = gdda_pkg::AW'(off_r);
        t_nxt      = alu_rsp.res;
        rerr_nxt   = 1'b0;
        state_nxt  = va_r ? gdda_pkg::ST_LOW : gdda_pkg::ST_FINISH;
      end
      gdda_pkg::ST_LOW: begin
        // t - 1 below zero means before day one
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = t_r;
        alu_req.b  = gdda_pkg::AW'(1);
        t_nxt      = alu_rsp.res;
        if (alu_rsp.neg) begin
          rerr_nxt  = 1'b1;
          state_nxt = gdda_pkg::ST_FINISH;
        end else begin
          state_nxt = gdda_pkg::ST_HIGH;
        end
      end
      gdda_pkg::ST_HIGH: begin
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = t_r;
        alu_req.b  = gdda_pkg::AW'(gdda_pkg::TOP_DAYS);
        rem_nxt    = t_r[gdda_pkg::SER_W-1:0];
        q400_nxt   = '0;
        q100_nxt   = '0;
        q4_nxt     = '0;
        q1_nxt     = '0;
        k_nxt      = 3'd4;
        if (!alu_rsp.neg) begin
          rerr_nxt  = 1'b1;
          state_nxt = gdda_pkg::ST_FINISH;
        end else begin
          state_nxt = gdda_pkg::ST_Q400;
        end
      end
      gdda_pkg::ST_Q400: begin
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = gdda_pkg::AW'(rem_r);
        alu_req.b  = gdda_pkg::AW'(gdda_pkg::DAYS_400Y) << k_r;
        q400_nxt   = {q400_r[3:0], !alu_rsp.neg};
        if (!alu_rsp.neg) begin
          rem_nxt = alu_rsp.res[gdda_pkg::SER_W-1:0];
        end
        if (k_r == 3'd0) begin
          k_nxt     = 3'd1;
          state_nxt = gdda_pkg::ST_Q100;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      gdda_pkg::ST_Q100: begin
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = gdda_pkg::AW'(rem_r);
        alu_req.b  = gdda_pkg::AW'(gdda_pkg::DAYS_100Y) << k_r;
        q100_nxt   = {q100_r[0], !alu_rsp.neg};
        if (!alu_rsp.neg) begin
          rem_nxt = alu_rsp.res[gdda_pkg::SER_W-1:0];
        end
        if (k_r == 3'd0) begin
          k_nxt     = 3'd4;
          state_nxt = gdda_pkg::ST_Q4;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      gdda_pkg::ST_Q4: begin
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = gdda_pkg::AW'(rem_r);
        alu_req.b  = gdda_pkg::AW'(gdda_pkg::DAYS_4Y) << k_r;
        q4_nxt     = {q4_r[3:0], !alu_rsp.neg};
        if (!alu_rsp.neg) begin
          rem_nxt = alu_rsp.res[gdda_pkg::SER_W-1:0];
        end
        if (k_r == 3'd0) begin
          k_nxt     = 3'd1;
          state_nxt = gdda_pkg::ST_Q1;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      gdda_pkg::ST_Q1: begin
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = gdda_pkg::AW'(rem_r);
        alu_req.b  = gdda_pkg::AW'(gdda_pkg::DAYS_1Y) << k_r;
        q1_nxt     = {q1_r[0], !alu_rsp.neg};
        if (!alu_rsp.neg) begin
          rem_nxt = alu_rsp.res[gdda_pkg::SER_W-1:0];
        end
        if (k_r == 3'd0) begin
          state_nxt = gdda_pkg::ST_YEAR;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      gdda_pkg::ST_YEAR: begin
        // leap when last year of a 4-year group, unless a plain century
        alu_req.op = gdda_pkg::ALU_ADD;
        alu_req.a  = gdda_pkg::AW'(rem_r);
        alu_req.b  = gdda_pkg::AW'(1);
        rem_nxt    = alu_rsp.res[gdda_pkg::SER_W-1:0];
        year_nxt   = year_c;
        leap_nxt   = (q1_r == 2'd3) && ((q4_r != 5'd24) || (q100_r == 2'd3));
        mon_nxt    = gdda_pkg::M_W'(1);
        state_nxt  = gdda_pkg::ST_MONTH;
      end
      gdda_pkg::ST_MONTH: begin
        alu_req.op = gdda_pkg::ALU_SUB;
        alu_req.a  = gdda_pkg::AW'(rem_r);
        alu_req.b  = gdda_pkg::AW'(gdda_pkg::month_days(mon_r, leap_r));
        if ((mon_r < gdda_pkg::M_W'(12)) && !alu_rsp.neg && !alu_rsp.zero) begin
          rem_nxt = alu_rsp.res[gdda_pkg::SER_W-1:0];
          mon_nxt = mon_r + gdda_pkg::M_W'(1);
        end else begin
          state_nxt = gdda_pkg::ST_FINISH;
        end
      end
      gdda_pkg::ST_FINISH: begin
        if (va_r && !rerr_r) begin
          o_day_nxt   = rem_r[gdda_pkg::D_W-1:0];
          o_month_nxt = mon_r;
          o_year_nxt  = year_r;
        end else begin
          o_day_nxt   = da_r;
          o_month_nxt = ma_r;
          o_year_nxt  = ya_r;
        end
        o_va_nxt       = va_r;
        o_vb_nxt       = vb_r;
        o_serial_nxt   = sa_r;
        o_rerr_nxt     = va_r && rerr_r;
        o_diff_nxt     = diff_r;
        o_before_nxt   = before_c;
        o_equal_nxt    = (da_r == db_r) && (ma_r == mb_r) && (ya_r == yb_r);
        out_strobe_nxt = 1'b1;
        state_nxt      = gdda_pkg::ST_IDLE;
      end
      default: state_nxt = gdda_pkg::ST_IDLE;
    endcase
  end

  assign busy               = (state_r != gdda_pkg::ST_IDLE);
  assign out_strobe         = out_strobe_r;
  assign out_valid_a        = o_va_r;
  assign out_valid_b        = o_vb_r;
  assign out_serial_a       = o_serial_r;
  assign out_sum_day        = o_day_r;
  assign out_sum_month      = o_month_r;
  assign out_sum_year       = o_year_r;
  assign out_range_error    = o_rerr_r;
  assign out_day_difference = o_diff_r;
  assign out_a_before_b     = o_before_r;
  assign out_a_equals_b     = o_equal_r;

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_invalid_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_a) |->
      (!out_range_error && (out_serial_a == '0) && (out_day_difference == '0)))
    else $error("invalid first date gave non-zero results");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_a && !out_range_error) |->
      ((out_sum_month >= gdda_pkg::M_W'(1)) && (out_sum_month <= gdda_pkg::M_W'(12))
       && (out_sum_day >= gdda_pkg::D_W'(1)) && (out_sum_day <= gdda_pkg::D_W'(31))))
    else $error("shifted date out of calendar range");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_a_equals_b) |-> !out_a_before_b)
    else $error("equal dates reported as ordered");

endmodule

@@ tb/gregorian_date_day_arithmetic_chk.sv @@
module gregorian_date_day_arithmetic_chk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [gdda_pkg::D_W-1:0]           in_day_a,
  input  logic [gdda_pkg::M_W-1:0]           in_month_a,
  input  logic [gdda_pkg::Y_W-1:0]           in_year_a,
  input  logic signed [gdda_pkg::OFF_W-1:0]  in_day_offset,
  input  logic [gdda_pkg::D_W-1:0]           in_day_b,
  input  logic [gdda_pkg::M_W-1:0]           in_month_b,
  input  logic [gdda_pkg::Y_W-1:0]           in_year_b,
  input  logic                               out_strobe,
  input  logic                               out_valid_a,
  input  logic                               out_valid_b,
  input  logic [gdda_pkg::SER_W-1:0]         out_serial_a,
  input  logic [gdda_pkg::D_W-1:0]           out_sum_day,
  input  logic [gdda_pkg::M_W-1:0]           out_sum_month,
  input  logic [gdda_pkg::Y_W-1:0]           out_sum_year,
  input  logic                               out_range_error,
  input  logic signed [gdda_pkg::DIFF_W-1:0] out_day_difference,
  input  logic                               out_a_before_b,
  input  logic                               out_a_equals_b,
  output int                                 errors,
  output int                                 pending,
  output int                                 checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        valid_a;
    logic                        valid_b;
    logic [gdda_pkg::SER_W-1:0]  serial_a;
    logic [gdda_pkg::D_W-1:0]    sum_day;
    logic [gdda_pkg::M_W-1:0]    sum_month;
    logic [gdda_pkg::Y_W-1:0]    sum_year;
    logic                        range_error;
    logic [gdda_pkg::DIFF_W-1:0] day_difference;
    logic                        a_before_b;
    logic                        a_equals_b;
  } date_result_t;

  date_result_t due_results[$];
  int n_err = 0;
  int n_checked = 0;

  function automatic bit leap_year(longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic longint days_in_month(longint m, longint y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit real_date(longint d, longint m, longint y);
    if (y < 1 || y > gdda_pkg::MAX_YEAR || m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= days_in_month(m, y);
  endfunction

  // days in all years ahead of year y
  function automatic longint days_before(longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint day_number(longint d, longint m, longint y);
    longint s;
    s = days_before(y);
    for (longint k = 1; k < m; k++) s += days_in_month(k, y);
    return s + d;
  endfunction

  function automatic void calendar_of(input longint s, output longint d, output longint m,
                                      output longint y);
    longint n, r, q400, q100, q4, q1;
    n = s - 1;
    q400 = n / gdda_pkg::DAYS_400Y;
    r = n % gdda_pkg::DAYS_400Y;
    q100 = r / gdda_pkg::DAYS_100Y;
    if (q100 > 3) q100 = 3;
    r -= q100 * gdda_pkg::DAYS_100Y;
    q4 = r / gdda_pkg::DAYS_4Y;
    r = r % gdda_pkg::DAYS_4Y;
    q1 = r / 365;
    if (q1 > 3) q1 = 3;
    r -= q1 * 365;
    y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    r += 1;
    m = 1;
    while (m < 12 && r > days_in_month(m, y)) begin
      r -= days_in_month(m, y);
      m++;
    end
    d = r;
  endfunction

  function automatic date_result_t compute_date_result(
    input logic [gdda_pkg::D_W-1:0] da, input logic [gdda_pkg::M_W-1:0] ma,
    input logic [gdda_pkg::Y_W-1:0] ya,
    input logic signed [gdda_pkg::OFF_W-1:0] off,
    input logic [gdda_pkg::D_W-1:0] db, input logic [gdda_pkg::M_W-1:0] mb,
    input logic [gdda_pkg::Y_W-1:0] yb);
    date_result_t r;
    bit va, vb;
    longint sa, sb, t, d, m, y;
    va = real_date(longint'(da), longint'(ma), longint'(ya));
    vb = real_date(longint'(db), longint'(mb), longint'(yb));
    sa = va ? day_number(longint'(da), longint'(ma), longint'(ya)) : 0;
    sb = vb ? day_number(longint'(db), longint'(mb), longint'(yb)) : 0;
    r.valid_a = va;
    r.valid_b = vb;
    r.serial_a = gdda_pkg::SER_W'(sa);
    r.sum_day = da;
    r.sum_month = ma;
    r.sum_year = ya;
    r.range_error = 1'b0;
    r.day_difference = '0;
    if (va) begin
      t = sa + longint'(off);
      if (t < 1 || t > days_before(longint'(gdda_pkg::MAX_YEAR) + 1)) begin
        r.range_error = 1'b1;
      end else begin
        calendar_of(t, d, m, y);
        r.sum_day = gdda_pkg::D_W'(d);
        r.sum_month = gdda_pkg::M_W'(m);
        r.sum_year = gdda_pkg::Y_W'(y);
      end
    end
    if (va && vb) r.day_difference = gdda_pkg::DIFF_W'(sa - sb);
    if (ya != yb) r.a_before_b = ya < yb;
    else if (ma != mb) r.a_before_b = ma < mb;
    else r.a_before_b = da < db;
    r.a_equals_b = (da == db) && (ma == mb) && (ya == yb);
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    date_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          n_err++;
          $display("%0t: result with no transaction outstanding, expected none, %s %0d",
                   $time, "actual serial", out_serial_a);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          check_field("valid_a", longint'(want.valid_a), longint'(out_valid_a));
          check_field("valid_b", longint'(want.valid_b), longint'(out_valid_b));
          check_field("serial_a", longint'(want.serial_a), longint'(out_serial_a));
          check_field("sum_day", longint'(want.sum_day), longint'(out_sum_day));
          check_field("sum_month", longint'(want.sum_month), longint'(out_sum_month));
          check_field("sum_year", longint'(want.sum_year), longint'(out_sum_year));
          check_field("range_error", longint'(want.range_error), longint'(out_range_error));
          check_field("day_difference", longint'($signed(want.day_difference)),
                      longint'(out_day_difference));
          check_field("a_before_b", longint'(want.a_before_b), longint'(out_a_before_b));
          check_field("a_equals_b", longint'(want.a_equals_b), longint'(out_a_equals_b));
        end
      end
      if (start && !busy) begin
        due_results.push_back(compute_date_result(in_day_a, in_month_a, in_year_a,
                                                  in_day_offset, in_day_b, in_month_b,
                                                  in_year_b));
      end
    end
    errors <= n_err;
    pending <= due_results.size();
    checked <= n_checked;
  end

endmodule

@@ tb/gregorian_date_day_arithmetic_tb.sv @@
module gregorian_date_day_arithmetic_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic [gdda_pkg::D_W-1:0]           in_day_a;
  logic [gdda_pkg::M_W-1:0]           in_month_a;
  logic [gdda_pkg::Y_W-1:0]           in_year_a;
  logic signed [gdda_pkg::OFF_W-1:0]  in_day_offset;
  logic [gdda_pkg::D_W-1:0]           in_day_b;
  logic [gdda_pkg::M_W-1:0]           in_month_b;
  logic [gdda_pkg::Y_W-1:0]           in_year_b;
  logic                               out_strobe;
  logic                               out_valid_a;
  logic                               out_valid_b;
  logic [gdda_pkg::SER_W-1:0]         out_serial_a;
  logic [gdda_pkg::D_W-1:0]           out_sum_day;
  logic [gdda_pkg::M_W-1:0]           out_sum_month;
  logic [gdda_pkg::Y_W-1:0]           out_sum_year;
  logic                               out_range_error;
  logic signed [gdda_pkg::DIFF_W-1:0] out_day_difference;
  logic                               out_a_before_b;
  logic                               out_a_equals_b;
  int                                 errors;
  int                                 pending;
  int                                 checked;

  typedef struct packed {
    logic [gdda_pkg::D_W-1:0]          da;
    logic [gdda_pkg::M_W-1:0]          ma;
    logic [gdda_pkg::Y_W-1:0]          ya;
    logic signed [gdda_pkg::OFF_W-1:0] off;
    logic [gdda_pkg::D_W-1:0]          db;
    logic [gdda_pkg::M_W-1:0]          mb;
    logic [gdda_pkg::Y_W-1:0]          yb;
  } date_request_t;

  date_request_t directed_q[$];
  int n_directed = 0;
  int n_random = 0;

  gregorian_date_day_arithmetic dut (.*);
  gregorian_date_day_arithmetic_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("gregorian_date_day_arithmetic verification failed");
    $finish;
  end

  function automatic date_request_t mk(int da, int ma, int ya, int off, int db, int mb, int yb);
    date_request_t r;
    r.da = gdda_pkg::D_W'(da);
    r.ma = gdda_pkg::M_W'(ma);
    r.ya = gdda_pkg::Y_W'(ya);
    r.off = gdda_pkg::OFF_W'(off);
    r.db = gdda_pkg::D_W'(db);
    r.mb = gdda_pkg::M_W'(mb);
    r.yb = gdda_pkg::Y_W'(yb);
    return r;
  endfunction

  function automatic logic [gdda_pkg::Y_W-1:0] pick_year();
    case ($urandom_range(0, 9))
      0: return gdda_pkg::Y_W'($urandom_range(1, 5));
      1: return gdda_pkg::Y_W'($urandom_range(9995, gdda_pkg::MAX_YEAR));
      2: return gdda_pkg::Y_W'(100 * $urandom_range(1, 99));
      3: return gdda_pkg::Y_W'(4 * $urandom_range(1, 2499));
      default: return gdda_pkg::Y_W'($urandom_range(1, gdda_pkg::MAX_YEAR));
    endcase
  endfunction

  function automatic void pick_date(output logic [gdda_pkg::D_W-1:0] d,
                                    output logic [gdda_pkg::M_W-1:0] m,
                                    output logic [gdda_pkg::Y_W-1:0] y);
    logic [gdda_pkg::D_W-1:0] last;
    if ($urandom_range(0, 9) == 0) begin
      // raw fields, mostly not a real date
      d = gdda_pkg::D_W'($urandom_range(0, 31));
      m = gdda_pkg::M_W'($urandom_range(0, 15));
      y = gdda_pkg::Y_W'($urandom_range(0, 16383));
    end else begin
      y = pick_year();
      m = gdda_pkg::M_W'($urandom_range(1, 12));
      last = gdda_pkg::month_days(m, ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0);
      d = ($urandom_range(0, 3) == 0) ? last : gdda_pkg::D_W'($urandom_range(1, last));
    end
  endfunction

  function automatic date_request_t random_request();
    date_request_t r;
    int span;
    pick_date(r.da, r.ma, r.ya);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: span = 800;
      4, 5: span = 40000;
      6: span = 3652059;
      7: span = 1;
      default: span = 0;
    endcase
    if (span == 0) r.off = gdda_pkg::OFF_W'($urandom);
    else r.off = gdda_pkg::OFF_W'($urandom_range(0, 2 * span) - span);
    case ($urandom_range(0, 9))
      0, 1: begin
        r.db = r.da;
        r.mb = r.ma;
        r.yb = r.ya;
      end
      2: begin
        r.db = gdda_pkg::D_W'($urandom_range(1, 31));
        r.mb = r.ma;
        r.yb = r.ya;
      end
      3: begin
        pick_date(r.db, r.mb, r.yb);
        r.yb = r.ya;
      end
      default: pick_date(r.db, r.mb, r.yb);
    endcase
    return r;
  endfunction

  task automatic drive(input date_request_t r);
    @(negedge clk);
    start <= 1'b1;
    in_day_a <= r.da;
    in_month_a <= r.ma;
    in_year_a <= r.ya;
    in_day_offset <= r.off;
    in_day_b <= r.db;
    in_month_b <= r.mb;
    in_year_b <= r.yb;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_day_a = '0;
    in_month_a = '0;
    in_year_a = '0;
    in_day_offset = '0;
    in_day_b = '0;
    in_month_b = '0;
    in_year_b = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_q.push_back(mk(1, 1, 1, 0, 1, 1, 1));
    directed_q.push_back(mk(1, 1, 1, -1, 31, 12, 9999));
    directed_q.push_back(mk(31, 12, 9999, 1, 1, 1, 1));
    directed_q.push_back(mk(31, 12, 9999, -3652058, 1, 1, 1));
    directed_q.push_back(mk(1, 1, 1, 3652058, 31, 12, 9999));
    directed_q.push_back(mk(15, 6, 5000, -4194304, 14, 6, 5000));
    directed_q.push_back(mk(1, 1, 1, 4194303, 2, 1, 1));
    directed_q.push_back(mk(29, 2, 2000, 365, 28, 2, 2000));
    directed_q.push_back(mk(29, 2, 1900, 1, 1, 3, 1900));
    directed_q.push_back(mk(28, 2, 2100, 1, 29, 2, 2100));
    directed_q.push_back(mk(29, 2, 2004, -60, 29, 2, 2003));
    directed_q.push_back(mk(0, 5, 2020, 10, 1, 5, 2020));
    directed_q.push_back(mk(31, 4, 2021, 1, 30, 4, 2021));
    directed_q.push_back(mk(10, 0, 2021, 1, 10, 13, 2021));
    directed_q.push_back(mk(10, 15, 0, 1, 10, 1, 1));
    directed_q.push_back(mk(31, 15, 16383, -1, 31, 15, 16383));
    directed_q.push_back(mk(1, 1, 10000, 1, 31, 12, 9999));
    directed_q.push_back(mk(31, 12, 1999, 1, 1, 1, 2000));
    directed_q.push_back(mk(20, 3, 1999, -20, 19, 4, 1999));
    directed_q.push_back(mk(5, 7, 1999, 0, 6, 7, 1999));
    directed_q.push_back(mk(6, 7, 1999, -6, 5, 7, 1999));
    directed_q.push_back(mk(1, 3, 2400, -1, 29, 2, 2400));

    foreach (directed_q[i]) begin
      drive(directed_q[i]);
      n_directed++;
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 18));
    end
    drain();

    for (int i = 0; i < 400; i++) begin
      // sender waits for the unit to empty completely
      if (i == 200) drain();
      drive(random_request());
      n_random++;
      if (i < 340 && (i % 100) >= 20 && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 18));
    end
    drain();
    repeat (40) @(negedge clk);

    $display("%0d directed and %0d random transactions sent, %0d results checked",
             n_directed, n_random, checked);
    $display("covered leap rules, malformed fields, range edges and full-width offsets");
    if (errors == 0 && pending == 0) begin
      $display("gregorian_date_day_arithmetic verification clean");
    end else begin
      $display("gregorian_date_day_arithmetic verification failed");
    end
    $finish;
  end

endmodule

@@ gregorian_date_day_arithmetic.f @@
sv/gdda_pkg.sv
sv/gdda_alu.sv
sv/gdda_serial.sv
sv/gregorian_date_day_arithmetic.sv
tb/gregorian_date_day_arithmetic_chk.sv
tb/gregorian_date_day_arithmetic_tb.sv
